### hw/rtl/rdmc_pkg.sv
`default_nettype none
package rdmc_pkg;

  localparam int DIST_W   = 13;
  localparam int DUTY_W   = 8;
  localparam int ANGLE_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  // run modes
  localparam logic [1:0] MODE_LINE   = 2'd0;
  localparam logic [1:0] MODE_AVOID  = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;

  // wheel direction codes
  localparam logic [1:0] DRV_OFF = 2'd0;
  localparam logic [1:0] DRV_FWD = 2'd1;
  localparam logic [1:0] DRV_REV = 2'd2;

  // manual motion codes
  localparam logic [2:0] MOT_STOP  = 3'd0;
  localparam logic [2:0] MOT_FWD   = 3'd1;
  localparam logic [2:0] MOT_BACK  = 3'd2;
  localparam logic [2:0] MOT_LEFT  = 3'd3;
  localparam logic [2:0] MOT_RIGHT = 3'd4;

  // command characters
  localparam logic [7:0] CMD_MODE_LINE   = 8'h31;
  localparam logic [7:0] CMD_MODE_AVOID  = 8'h32;
  localparam logic [7:0] CMD_MODE_MANUAL = 8'h33;
  localparam logic [7:0] CMD_FWD         = 8'h46;
  localparam logic [7:0] CMD_BACK        = 8'h42;
  localparam logic [7:0] CMD_LEFT        = 8'h4C;
  localparam logic [7:0] CMD_RIGHT       = 8'h52;
  localparam logic [7:0] CMD_STOP        = 8'h53;
  localparam logic [7:0] CMD_SPEED       = 8'h56;
  localparam logic [7:0] CMD_SERVO_TGL   = 8'h58;
  localparam logic [7:0] CMD_SERVO_DN    = 8'h43;
  localparam logic [7:0] CMD_SERVO_UP    = 8'h44;

  // servo limits
  localparam logic [ANGLE_W-1:0] SERVO_CENTER = 8'd90;
  localparam logic [ANGLE_W-1:0] SERVO_STEP   = 8'd15;
  localparam logic [ANGLE_W-1:0] SERVO_MAX    = 8'd180;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_STOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_CLEAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_NEAR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_FAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_TURN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_SLOW  = 3'd7;

  // configuration reset values
  localparam logic [DIST_W-1:0] RST_FRONT_STOP = 13'd320;
  localparam logic [DIST_W-1:0] RST_SIDE_CLEAR = 13'd480;
  localparam logic [DIST_W-1:0] RST_WALL_NEAR  = 13'd240;
  localparam logic [DIST_W-1:0] RST_WALL_FAR   = 13'd400;
  localparam logic [DUTY_W-1:0] RST_CRUISE     = 8'd150;
  localparam logic [DUTY_W-1:0] RST_TRACK_TURN = 8'd200;
  localparam logic [DUTY_W-1:0] RST_FAST       = 8'd255;
  localparam logic [DUTY_W-1:0] RST_TRIM_SLOW  = 8'd100;

  typedef struct packed {
    logic              cmd_valid;
    logic [7:0]        cmd_byte;
    logic [5:0]        line_bits;
    logic [DIST_W-1:0] left_dist;
    logic [DIST_W-1:0] front_dist;
    logic [DIST_W-1:0] right_dist;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         run_mode;
    logic [1:0]         left_drive;
    logic [1:0]         right_drive;
    logic [DUTY_W-1:0]  left_duty;
    logic [DUTY_W-1:0]  right_duty;
    logic [ANGLE_W-1:0] servo_position;
    logic               servo_on;
    logic               fast_on;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         motion;
    logic               fast;
    logic               servo_en;
    logic [ANGLE_W-1:0] servo_target;
    logic [ANGLE_W-1:0] servo_sent;
  } ctl_state_t;

  typedef struct packed {
    logic [DIST_W-1:0] front_stop_dist;
    logic [DIST_W-1:0] side_clear_dist;
    logic [DIST_W-1:0] wall_near_dist;
    logic [DIST_W-1:0] wall_far_dist;
    logic [DUTY_W-1:0] cruise_pwm;
    logic [DUTY_W-1:0] track_turn_pwm;
    logic [DUTY_W-1:0] fast_pwm;
    logic [DUTY_W-1:0] trim_slow_pwm;
  } cfg_regs_t;

endpackage
`default_nettype wire

### hw/rtl/rdmc_state.sv
`default_nettype none
module rdmc_state import rdmc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic       cmd_valid,
  input  wire logic [7:0] cmd_byte,
  output ctl_state_t      state_nxt
);

  ctl_state_t           state_r;
  logic                 man;
  logic [ANGLE_W:0]     up_sum;
  logic [ANGLE_W-1:0]   dn_val;
  logic [ANGLE_W-1:0]   up_val;

  assign man    = (state_r.mode == MODE_MANUAL);
  assign up_sum = {1'b0, state_r.servo_target} + {1'b0, SERVO_STEP};
  assign dn_val = (state_r.servo_target > SERVO_STEP) ?
                  (state_r.servo_target - SERVO_STEP) : '0;
  assign up_val = (up_sum > {1'b0, SERVO_MAX}) ? SERVO_MAX : up_sum[ANGLE_W-1:0];

  // command applied ahead of the drive decision
  always_comb begin
    state_nxt = state_r;
    if (cmd_valid) begin
      unique case (cmd_byte)
        CMD_MODE_LINE:   state_nxt.mode = MODE_LINE;
        CMD_MODE_AVOID:  state_nxt.mode = MODE_AVOID;
        CMD_MODE_MANUAL: state_nxt.mode = MODE_MANUAL;
        CMD_FWD:   if (man) state_nxt.motion = MOT_FWD;
        CMD_BACK:  if (man) state_nxt.motion = MOT_BACK;
        CMD_LEFT:  if (man) state_nxt.motion = MOT_LEFT;
        CMD_RIGHT: if (man) state_nxt.motion = MOT_RIGHT;
        CMD_STOP:  if (man) state_nxt.motion = MOT_STOP;
        CMD_SPEED: if (man) state_nxt.fast = ~state_r.fast;
        CMD_SERVO_TGL: begin
          if (man) begin
            state_nxt.servo_en = ~state_r.servo_en;
            // switching off centres the servo, target kept
            if (state_r.servo_en) state_nxt.servo_sent = SERVO_CENTER;
          end
        end
        CMD_SERVO_DN: begin
          if (man && state_r.servo_en) begin
            state_nxt.servo_target = dn_val;
            state_nxt.servo_sent   = dn_val;
          end
        end
        CMD_SERVO_UP: begin
          if (man && state_r.servo_en) begin
            state_nxt.servo_target = up_val;
            state_nxt.servo_sent   = up_val;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode         <= MODE_LINE;
      state_r.motion       <= MOT_STOP;
      state_r.fast         <= 1'b1;
      state_r.servo_en     <= 1'b0;
      state_r.servo_target <= SERVO_CENTER;
      state_r.servo_sent   <= SERVO_CENTER;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rdmc_drive.sv
`default_nettype none
module rdmc_drive import rdmc_pkg::*; (
  input  ctl_state_t st,
  input  cfg_regs_t  cfg,
  input  in_item_t   item,
  output out_item_t  res
);

  logic [1:0]        ld, rd;
  logic [DUTY_W-1:0] lp, rp, sp;
  logic [5:0]        seen;

  assign seen = ~item.line_bits;
  assign sp   = st.fast ? cfg.fast_pwm : cfg.cruise_pwm;

  always_comb begin
    ld = DRV_OFF;
    rd = DRV_OFF;
    lp = '0;
    rp = '0;
    unique case (st.mode)
      MODE_LINE: begin
        priority if (seen[2] && seen[3]) begin
          ld = DRV_FWD; rd = DRV_FWD; lp = cfg.cruise_pwm; rp = cfg.cruise_pwm;
        end else if (seen[0] || seen[1]) begin
          ld = DRV_REV; rd = DRV_FWD; lp = cfg.track_turn_pwm; rp = cfg.track_turn_pwm;
        end else if (seen[4] || seen[5]) begin
          ld = DRV_FWD; rd = DRV_REV; lp = cfg.track_turn_pwm; rp = cfg.track_turn_pwm;
        end else begin
          ld = DRV_OFF; rd = DRV_OFF; lp = '0; rp = '0;
        end
      end
      MODE_AVOID: begin
        lp = cfg.cruise_pwm;
        rp = cfg.cruise_pwm;
        priority if (item.front_dist < cfg.front_stop_dist) begin
          priority if (item.right_dist > item.left_dist &&
                       item.right_dist > cfg.side_clear_dist) begin
            ld = DRV_FWD; rd = DRV_REV;
          end else if (item.left_dist > cfg.side_clear_dist) begin
            ld = DRV_REV; rd = DRV_FWD;
          end else begin
            ld = DRV_REV; rd = DRV_REV;
          end
        end else if (item.right_dist < cfg.wall_near_dist) begin
          ld = DRV_FWD; rd = DRV_FWD; lp = cfg.trim_slow_pwm; rp = cfg.track_turn_pwm;
        end else if (item.right_dist > cfg.wall_far_dist) begin
          ld = DRV_FWD; rd = DRV_FWD; lp = cfg.track_turn_pwm; rp = cfg.trim_slow_pwm;
        end else begin
          ld = DRV_FWD; rd = DRV_FWD;
        end
      end
      MODE_MANUAL: begin
        unique case (st.motion)
          MOT_FWD:   begin ld = DRV_FWD; rd = DRV_FWD; lp = sp; rp = sp; end
          MOT_BACK:  begin ld = DRV_REV; rd = DRV_REV; lp = sp; rp = sp; end
          MOT_LEFT:  begin ld = DRV_REV; rd = DRV_FWD; lp = sp; rp = sp; end
          MOT_RIGHT: begin ld = DRV_FWD; rd = DRV_REV; lp = sp; rp = sp; end
          default:   begin ld = DRV_OFF; rd = DRV_OFF; lp = '0; rp = '0; end
        endcase
      end
      default: begin
        ld = DRV_OFF; rd = DRV_OFF; lp = '0; rp = '0;
      end
    endcase
  end

  always_comb begin
    res.run_mode       = st.mode;
    res.left_drive     = ld;
    res.right_drive    = rd;
    res.left_duty      = lp;
    res.right_duty     = rp;
    res.servo_position = st.servo_sent;
    res.servo_on       = st.servo_en;
    res.fast_on        = st.fast;
  end

endmodule
`default_nettype wire

### hw/rtl/robot_drive_mode_controller.sv
`default_nettype none
// drive mode controller for a two-wheel robot, one control tick per input beat
// input channel: in_valid / in_stall / in_data, one beat holds the optional command
//   byte, six line sensor bits and the left, front and right range readings
// result channel: out_valid / out_stall / out_data, one beat per input beat, carrying
//   run mode, wheel directions and duties, servo angle and the servo and speed flags
// configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is held
//   high so every write is accepted; write only while no tick is in flight
// path: a taken tick is held in the input register, is decoded combinationally and its
//   result is registered in the output register when the tick moves on
// throughput: one tick per cycle while out_stall is low; the command decode and drive
//   selection are combinational compares and muxes between the two registers
// the robot state (mode, manual motion, flags, servo) is updated only as a tick moves
//   into the output register, so the next tick always sees it
// reset: control state and configuration go to their defaults, both valids drop
// stall: a stalled result holds the output register; the input register then fills and
//   in_stall stays high while it holds a tick, no tick is lost or doubled
module robot_drive_mode_controller import rdmc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  in_item_t                   in_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  cfg_regs_t  cfg_r;
  ctl_state_t state_nxt;
  out_item_t  result;
  logic       advance;
  logic       fire;

  // output register free or being emptied this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.front_stop_dist <= RST_FRONT_STOP;
      cfg_r.side_clear_dist <= RST_SIDE_CLEAR;
      cfg_r.wall_near_dist  <= RST_WALL_NEAR;
      cfg_r.wall_far_dist   <= RST_WALL_FAR;
      cfg_r.cruise_pwm      <= RST_CRUISE;
      cfg_r.track_turn_pwm  <= RST_TRACK_TURN;
      cfg_r.fast_pwm        <= RST_FAST;
      cfg_r.trim_slow_pwm   <= RST_TRIM_SLOW;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRONT_STOP: cfg_r.front_stop_dist <= cfg_data[DIST_W-1:0];
        CFG_SIDE_CLEAR: cfg_r.side_clear_dist <= cfg_data[DIST_W-1:0];
        CFG_WALL_NEAR:  cfg_r.wall_near_dist  <= cfg_data[DIST_W-1:0];
        CFG_WALL_FAR:   cfg_r.wall_far_dist   <= cfg_data[DIST_W-1:0];
        CFG_CRUISE:     cfg_r.cruise_pwm      <= cfg_data[DUTY_W-1:0];
        CFG_TRACK_TURN: cfg_r.track_turn_pwm  <= cfg_data[DUTY_W-1:0];
        CFG_FAST:       cfg_r.fast_pwm        <= cfg_data[DUTY_W-1:0];
        CFG_TRIM_SLOW:  cfg_r.trim_slow_pwm   <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // command decode and robot state, committed when the tick moves on
  rdmc_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .cmd_valid (in_item_r.cmd_valid),
    .cmd_byte  (in_item_r.cmd_byte),
    .state_nxt (state_nxt)
  );

  // wheel direction and duty selection from the post-command state
  rdmc_drive u_drive (
    .st   (state_nxt),
    .cfg  (cfg_r),
    .item (in_item_r),
    .res  (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

endmodule
`default_nettype wire

### dv/testbench.sv
module testbench;
  import rdmc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // clock and a single synchronous reset at the start of the run
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  // every block input is known from time zero
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  robot_drive_mode_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the robot state and of the configuration, both at their reset values
  ctl_state_t robot = '{mode: MODE_LINE, motion: MOT_STOP, fast: 1'b1, servo_en: 1'b0,
                        servo_target: SERVO_CENTER, servo_sent: SERVO_CENTER};
  cfg_regs_t  limits = '{front_stop_dist: RST_FRONT_STOP, side_clear_dist: RST_SIDE_CLEAR,
                         wall_near_dist: RST_WALL_NEAR, wall_far_dist: RST_WALL_FAR,
                         cruise_pwm: RST_CRUISE, track_turn_pwm: RST_TRACK_TURN,
                         fast_pwm: RST_FAST, trim_slow_pwm: RST_TRIM_SLOW};

  in_item_t  tick_q [$];   // control ticks still waiting to be offered
  out_item_t steer_q [$];  // predicted drive outputs, oldest first
  int        ticks_queued = 0;
  int        steers_seen  = 0;
  int        faults       = 0;
  bit        calm         = 1'b0;  // no idling on either side while set

  logic [7:0] all_cmds [12] = '{CMD_MODE_LINE, CMD_MODE_AVOID, CMD_MODE_MANUAL, CMD_FWD,
                                CMD_BACK, CMD_LEFT, CMD_RIGHT, CMD_STOP, CMD_SPEED,
                                CMD_SERVO_TGL, CMD_SERVO_DN, CMD_SERVO_UP};
  logic [7:0] manual_cmds [9] = '{CMD_FWD, CMD_BACK, CMD_LEFT, CMD_RIGHT, CMD_STOP,
                                  CMD_SPEED, CMD_SERVO_TGL, CMD_SERVO_DN, CMD_SERVO_UP};

  // one control tick: command first, then the wheel decision for the resulting mode
  function automatic out_item_t steer_tick(in_item_t tick);
    out_item_t  r;
    logic       man;
    logic [5:0] seen;
    logic [7:0] sp;
    r = '0;  // wheels off with zero duty unless a rule below says otherwise
    man = (robot.mode == MODE_MANUAL);
    if (tick.cmd_valid) begin
      case (tick.cmd_byte)
        CMD_MODE_LINE:   robot.mode = MODE_LINE;
        CMD_MODE_AVOID:  robot.mode = MODE_AVOID;
        CMD_MODE_MANUAL: robot.mode = MODE_MANUAL;
        CMD_FWD:   if (man) robot.motion = MOT_FWD;
        CMD_BACK:  if (man) robot.motion = MOT_BACK;
        CMD_LEFT:  if (man) robot.motion = MOT_LEFT;
        CMD_RIGHT: if (man) robot.motion = MOT_RIGHT;
        CMD_STOP:  if (man) robot.motion = MOT_STOP;
        CMD_SPEED: if (man) robot.fast = !robot.fast;
        CMD_SERVO_TGL: if (man) begin
          robot.servo_en = !robot.servo_en;
          // switching off centres the servo but the target is remembered
          if (!robot.servo_en) robot.servo_sent = SERVO_CENTER;
        end
        CMD_SERVO_DN: if (man && robot.servo_en) begin
          robot.servo_target = (robot.servo_target > SERVO_STEP) ?
                               robot.servo_target - SERVO_STEP : '0;
          robot.servo_sent = robot.servo_target;
        end
        CMD_SERVO_UP: if (man && robot.servo_en) begin
          robot.servo_target = (int'(robot.servo_target) + int'(SERVO_STEP) >
                                int'(SERVO_MAX)) ? SERVO_MAX :
                               robot.servo_target + SERVO_STEP;
          robot.servo_sent = robot.servo_target;
        end
        default: ;
      endcase
    end
    case (robot.mode)
      MODE_LINE: begin
        seen = ~tick.line_bits;  // a low sensor bit means the line is under it
        if (seen[2] && seen[3])
          {r.left_drive, r.right_drive, r.left_duty, r.right_duty} =
            {DRV_FWD, DRV_FWD, limits.cruise_pwm, limits.cruise_pwm};
        else if (seen[0] || seen[1])
          {r.left_drive, r.right_drive, r.left_duty, r.right_duty} =
            {DRV_REV, DRV_FWD, limits.track_turn_pwm, limits.track_turn_pwm};
        else if (seen[4] || seen[5])
          {r.left_drive, r.right_drive, r.left_duty, r.right_duty} =
            {DRV_FWD, DRV_REV, limits.track_turn_pwm, limits.track_turn_pwm};
      end
      MODE_AVOID: begin
        if (tick.front_dist < limits.front_stop_dist) begin
          // blocked ahead: turn towards the roomier side, or back off
          if (tick.right_dist > tick.left_dist && tick.right_dist > limits.side_clear_dist)
            {r.left_drive, r.right_drive} = {DRV_FWD, DRV_REV};
          else if (tick.left_dist > limits.side_clear_dist)
            {r.left_drive, r.right_drive} = {DRV_REV, DRV_FWD};
          else
            {r.left_drive, r.right_drive} = {DRV_REV, DRV_REV};
          {r.left_duty, r.right_duty} = {limits.cruise_pwm, limits.cruise_pwm};
        end else if (tick.right_dist < limits.wall_near_dist)
          {r.left_drive, r.right_drive, r.left_duty, r.right_duty} =
            {DRV_FWD, DRV_FWD, limits.trim_slow_pwm, limits.track_turn_pwm};
        else if (tick.right_dist > limits.wall_far_dist)
          {r.left_drive, r.right_drive, r.left_duty, r.right_duty} =
            {DRV_FWD, DRV_FWD, limits.track_turn_pwm, limits.trim_slow_pwm};
        else
          {r.left_drive, r.right_drive, r.left_duty, r.right_duty} =
            {DRV_FWD, DRV_FWD, limits.cruise_pwm, limits.cruise_pwm};
      end
      MODE_MANUAL: begin
        sp = robot.fast ? limits.fast_pwm : limits.cruise_pwm;
        case (robot.motion)
          MOT_FWD:   {r.left_drive, r.right_drive} = {DRV_FWD, DRV_FWD};
          MOT_BACK:  {r.left_drive, r.right_drive} = {DRV_REV, DRV_REV};
          MOT_LEFT:  {r.left_drive, r.right_drive} = {DRV_REV, DRV_FWD};
          MOT_RIGHT: {r.left_drive, r.right_drive} = {DRV_FWD, DRV_REV};
          default:   ;
        endcase
        if (robot.motion inside {MOT_FWD, MOT_BACK, MOT_LEFT, MOT_RIGHT})
          {r.left_duty, r.right_duty} = {sp, sp};
      end
      default: ;
    endcase
    r.run_mode       = robot.mode;
    r.servo_position = robot.servo_sent;
    r.servo_on       = robot.servo_en;
    r.fast_on        = robot.fast;
    return r;
  endfunction

  // sender: offers queued ticks with random gaps, holds a stalled beat unchanged,
  // and predicts the drive outputs as each beat is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        steer_q.push_back(steer_tick(in_data));
      end
      if (in_valid && in_stall) begin
        // hold the beat until it is taken
      end else if (tick_q.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
        in_valid <= 1'b1;
        in_data  <= tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  // receiver: random back-pressure, every taken result beat checked against the oldest
  // prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        steers_seen++;
        if (steer_q.size() == 0) begin
          $error("result beat with no prediction waiting");
          faults++;
        end else begin
          want = steer_q.pop_front();
          check_field("run_mode", want.run_mode, out_data.run_mode);
          check_field("left_drive", want.left_drive, out_data.left_drive);
          check_field("right_drive", want.right_drive, out_data.right_drive);
          check_field("left_duty", want.left_duty, out_data.left_duty);
          check_field("right_duty", want.right_duty, out_data.right_duty);
          check_field("servo_position", want.servo_position, out_data.servo_position);
          check_field("servo_on", want.servo_on, out_data.servo_on);
          check_field("fast_on", want.fast_on, out_data.fast_on);
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 26);
    end
  end

  function automatic in_item_t noise_tick();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t mk(logic cv, logic [7:0] cb, logic [5:0] lb,
                                  logic [DIST_W-1:0] l, logic [DIST_W-1:0] f,
                                  logic [DIST_W-1:0] r);
    return '{cmd_valid: cv, cmd_byte: cb, line_bits: lb,
             left_dist: l, front_dist: f, right_dist: r};
  endfunction

  // a reading near a threshold most of the time, anywhere in range otherwise
  function automatic logic [DIST_W-1:0] range_pick(logic [DIST_W-1:0] th);
    int v;
    case ($urandom_range(3))
      0:       v = int'($urandom_range(8191));
      1:       v = int'(th);
      default: v = int'(th) + int'($urandom_range(40)) - 20;
    endcase
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return v[DIST_W-1:0];
  endfunction

  task automatic send(in_item_t t);
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  task automatic send_cmd(logic [7:0] cmd);
    in_item_t t;
    t = noise_tick();
    t.cmd_valid = 1'b1;
    t.cmd_byte  = cmd;
    send(t);
  endtask

  // wait until every predicted beat has come back, then let the pipeline empty
  task automatic settle();
    while (steers_seen < ticks_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FRONT_STOP: limits.front_stop_dist = val;
      CFG_SIDE_CLEAR: limits.side_clear_dist = val;
      CFG_WALL_NEAR:  limits.wall_near_dist  = val;
      CFG_WALL_FAR:   limits.wall_far_dist   = val;
      CFG_CRUISE:     limits.cruise_pwm      = val[DUTY_W-1:0];
      CFG_TRACK_TURN: limits.track_turn_pwm  = val[DUTY_W-1:0];
      CFG_FAST:       limits.fast_pwm        = val[DUTY_W-1:0];
      CFG_TRIM_SLOW:  limits.trim_slow_pwm   = val[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_limits(logic [DIST_W-1:0] fs, logic [DIST_W-1:0] sc,
                                logic [DIST_W-1:0] wn, logic [DIST_W-1:0] wf,
                                logic [DUTY_W-1:0] cr, logic [DUTY_W-1:0] tt,
                                logic [DUTY_W-1:0] fa, logic [DUTY_W-1:0] ts);
    reg_write(CFG_FRONT_STOP, fs);
    reg_write(CFG_SIDE_CLEAR, sc);
    reg_write(CFG_WALL_NEAR, wn);
    reg_write(CFG_WALL_FAR, wf);
    reg_write(CFG_CRUISE, CFG_DATA_W'(cr));
    reg_write(CFG_TRACK_TURN, CFG_DATA_W'(tt));
    reg_write(CFG_FAST, CFG_DATA_W'(fa));
    reg_write(CFG_TRIM_SLOW, CFG_DATA_W'(ts));
  endtask

  // mostly well-formed runs in one mode with random content, some servo sweeps that
  // each hit one clamp, and a share of pure noise
  task automatic random_phase(int quota);
    int       start;
    int       kind;
    in_item_t t;
    logic [7:0] dir;
    start = ticks_queued;
    while (ticks_queued - start < quota) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        send_cmd(CMD_MODE_LINE);
        repeat ($urandom_range(20, 5)) begin
          t = noise_tick();
          t.cmd_valid = ($urandom_range(9) == 0);
          t.cmd_byte  = all_cmds[$urandom_range(11)];
          send(t);
        end
      end else if (kind < 50) begin
        send_cmd(CMD_MODE_AVOID);
        repeat ($urandom_range(20, 5)) begin
          t = noise_tick();
          t.cmd_valid  = ($urandom_range(9) == 0);
          t.cmd_byte   = all_cmds[$urandom_range(11)];
          t.left_dist  = range_pick(limits.side_clear_dist);
          t.front_dist = range_pick(limits.front_stop_dist);
          case ($urandom_range(3))
            0:       t.right_dist = range_pick(limits.wall_near_dist);
            1:       t.right_dist = range_pick(limits.wall_far_dist);
            2:       t.right_dist = range_pick(limits.side_clear_dist);
            default: t.right_dist = range_pick(t.left_dist);  // right against left
          endcase
          send(t);
        end
      end else if (kind < 75) begin
        send_cmd(CMD_MODE_MANUAL);
        repeat ($urandom_range(25, 5)) begin
          t = noise_tick();
          t.cmd_valid = ($urandom_range(9) < 7);
          t.cmd_byte  = ($urandom_range(19) == 0) ? all_cmds[$urandom_range(11)] :
                        manual_cmds[$urandom_range(8)];
          send(t);
        end
      end else if (kind < 85) begin
        // whichever way the toggle lands, one of the two runs steps an enabled servo
        // far enough to reach the clamp from any angle
        send_cmd(CMD_MODE_MANUAL);
        dir = $urandom_range(1) ? CMD_SERVO_UP : CMD_SERVO_DN;
        repeat (2) begin
          send_cmd(CMD_SERVO_TGL);
          repeat (12) send_cmd(dir);
        end
      end else begin
        repeat ($urandom_range(10, 3)) send(noise_tick());
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed ticks with the reset configuration
    send(mk(1'b0, 8'h00, 6'b000000, '0, '0, '0));             // centre pair sees line
    send(mk(1'b1, CMD_FWD, 6'b111111, 13'h1FFF, 13'h1FFF, 13'h1FFF)); // ignored, lost
    send(mk(1'b0, 8'hFF, 6'b111110, '0, '0, '0));             // line on the far left
    send(mk(1'b0, 8'hFF, 6'b011111, '0, '0, '0));             // line on the far right
    send(mk(1'b1, CMD_MODE_AVOID, 6'b101010, '0, '0, 13'h1FFF)); // escape to the right
    send(mk(1'b0, 8'h00, 6'b010101, 13'h1FFF, '0, '0));       // escape to the left
    send(mk(1'b0, 8'h00, 6'b111111, 13'd100, '0, 13'd100));   // boxed in, reverse
    send(mk(1'b1, CMD_SERVO_TGL, 6'b0, '0, 13'h1FFF, '0));    // ignored, wall too close
    send(mk(1'b1, CMD_SPEED, 6'b0, '0, 13'h1FFF, 13'h1FFF));  // ignored, wall too far
    send(mk(1'b0, 8'h00, 6'b0, 13'd400, 13'd320, 13'd320));   // front at limit, cruise
    send_cmd(CMD_MODE_MANUAL);
    send_cmd(CMD_FWD);
    send_cmd(CMD_BACK);
    send_cmd(CMD_LEFT);
    send_cmd(CMD_RIGHT);
    send_cmd(CMD_SPEED);
    send_cmd(CMD_STOP);
    send_cmd(CMD_SERVO_DN);   // servo still off, nothing moves
    send_cmd(CMD_SERVO_TGL);
    send_cmd(CMD_SERVO_UP);
    send_cmd(CMD_SERVO_UP);
    send_cmd(CMD_SERVO_TGL);  // off: centred, target kept
    send_cmd(CMD_SERVO_TGL);
    send_cmd(CMD_SERVO_DN);   // steps from the kept target
    send_cmd(8'h00);          // unknown byte
    send_cmd(CMD_MODE_LINE);  // leaving manual keeps the flags
    random_phase(200);
    settle();

    // random settings
    program_limits(DIST_W'($urandom_range(8191)), DIST_W'($urandom_range(8191)),
                   DIST_W'($urandom_range(8191)), DIST_W'($urandom_range(8191)),
                   DUTY_W'($urandom_range(255)), DUTY_W'($urandom_range(255)),
                   DUTY_W'($urandom_range(255)), DUTY_W'($urandom_range(255)));
    random_phase(210);
    settle();

    // everything at zero
    program_limits('0, '0, '0, '0, '0, '0, '0, '0);
    random_phase(200);
    settle();

    // everything at full scale, with a long stretch free of gaps and stalls
    calm = 1'b1;
    program_limits(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    random_phase(210);
    settle();
    calm = 1'b0;

    // short distances so the readings cross several limits often
    program_limits(DIST_W'($urandom_range(800)), DIST_W'($urandom_range(800)),
                   DIST_W'($urandom_range(800)), DIST_W'($urandom_range(800)),
                   DUTY_W'($urandom_range(255)), DUTY_W'($urandom_range(255)),
                   DUTY_W'($urandom_range(255)), DUTY_W'($urandom_range(255)));
    random_phase(210);
    settle();

    // back to the power-up settings
    program_limits(RST_FRONT_STOP, RST_SIDE_CLEAR, RST_WALL_NEAR, RST_WALL_FAR,
                   RST_CRUISE, RST_TRACK_TURN, RST_FAST, RST_TRIM_SLOW);
    random_phase(200);
    settle();

    if (steer_q.size() != 0) begin
      $error("%0d predicted beats never arrived", steer_q.size());
      faults++;
    end
    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
